// ===== src/iss_pkg.sv =====
// Shared types and constants for the integer set sorter.
package iss_pkg;

   localparam int unsigned ISS_MAX_ITEMS = 64;
   localparam int unsigned ISS_DATA_W    = 32;

   typedef enum logic {
      ISS_LOAD,
      ISS_DRAIN
   } iss_state_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic                          insert;
      logic                          shift;
      logic signed [ISS_DATA_W-1:0]  value;
   } iss_cell_ctl_type;

endpackage

// ===== src/integer_set_sorter_core.sv =====
// Top level of the integer set sorter: cell chain, load/drain control and stream ports.
//
// Elements stream in one beat per cycle and are kept in ascending order at all times by a
// row of MAX_ITEMS cells: each beat is compared against every cell in parallel and
// inserted in the same cycle, the cells behind it moving one place along. The beat with
// tlast closes the set; from the next cycle the cells drain through the head, one result
// beat per cycle while rsp_tready is high, and the input side is held off (req_tready low)
// during the drain. Beats beyond MAX_ITEMS are dropped and every result of that set then
// carries rsp_tuser high; a closing beat that is dropped still closes the set.
module integer_set_sorter_core
   import iss_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = ISS_MAX_ITEMS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ISS_DATA_W-1:0]  req_tdata,   // [31:0] value
   input  logic                   req_tlast,   // last
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ISS_DATA_W-1:0]  rsp_tdata,   // [31:0] sorted_value
   output logic                   rsp_tlast,   // final_res
   output logic                   rsp_tuser    // [0] overflow
);

   localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

   iss_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;
   iss_cell_ctl_type  ctl;

   logic signed [ISS_DATA_W-1:0] cell_value  [MAX_ITEMS];
   logic                         cell_before [MAX_ITEMS];

   logic req_beat, rsp_beat, full;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign full     = (count_ff == CNT_W'(MAX_ITEMS));

   assign ctl.insert = req_beat && !full;
   assign ctl.shift  = rsp_beat;
   assign ctl.value  = $signed(req_tdata);

   generate
      for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
         logic                         prev_before;
         logic signed [ISS_DATA_W-1:0] prev_value;
         logic signed [ISS_DATA_W-1:0] next_value;

         if (i == 0) begin : g_head
            assign prev_before = 1'b0;
            assign prev_value  = ctl.value;
         end else begin : g_body
            assign prev_before = cell_before[i-1];
            assign prev_value  = cell_value[i-1];
         end

         if (i == MAX_ITEMS - 1) begin : g_tail
            assign next_value = '0;
         end else begin : g_inner
            assign next_value = cell_value[i+1];
         end

         iss_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (count_ff > CNT_W'(i)),
            .prev_before (prev_before),
            .prev_value  (prev_value),
            .next_value  (next_value),
            .precedes    (cell_before[i]),
            .value       (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ISS_LOAD: begin
            req_tready = 1'b1;
            if (req_beat) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = ISS_DRAIN;
               end
            end
         end
         ISS_DRAIN: begin
            rsp_tvalid = 1'b1;
            if (rsp_beat) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in   = ISS_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ISS_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ISS_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_tdata = cell_value[0];
   assign rsp_tlast = (count_ff == CNT_W'(1));
   assign rsp_tuser = dropped_ff;

   // A draining set always has at least one element left.
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ISS_DRAIN |-> count_ff != '0)
      else $error("drain with empty chain");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("element count beyond capacity");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_tlast |=> count_ff == '0 && state_ff == ISS_LOAD && !dropped_ff)
      else $error("set not cleared after final beat");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_tlast |=> $signed(rsp_tdata) >= $signed($past(rsp_tdata)))
      else $error("results out of order");

endmodule

// ===== src/iss_cell.sv =====
// One cell of the insertion chain: holds one element, inserts or shifts toward the head.
module iss_cell
   import iss_pkg::*;
(
   input  logic                          clock,
   input  iss_cell_ctl_type              ctl,
   input  logic                          occupied,
   input  logic                          prev_before,
   input  logic signed [ISS_DATA_W-1:0]  prev_value,
   input  logic signed [ISS_DATA_W-1:0]  next_value,
   output logic                          precedes,
   output logic signed [ISS_DATA_W-1:0]  value
);

   logic signed [ISS_DATA_W-1:0] value_ff;
   logic signed [ISS_DATA_W-1:0] value_in;

   // Empty cells act as +infinity, so the new element lands before them.
   assign precedes = !occupied || (ctl.value < value_ff);
   assign value    = value_ff;

   always_comb begin
      priority if (ctl.insert && precedes) begin
         // cells past the insertion point take their left neighbor's element
         value_in = prev_before ? prev_value : ctl.value;
      end else if (ctl.shift) begin
         value_in = next_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
